// ===== src/url_cache_strategy_classifier_defines.svh =====
`ifndef URL_CACHE_STRATEGY_CLASSIFIER_DEFINES_SVH
`define URL_CACHE_STRATEGY_CLASSIFIER_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define UCSC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define UCSC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ucsc_pkg.sv =====
package ucsc_pkg;

    localparam int unsigned WinLen   = 12;
    localparam int unsigned NumSens  = 9;
    localparam int unsigned NumExt   = 6;
    localparam int unsigned TailMax  = 6;
    localparam int unsigned WinIdxW  = $clog2(WinLen);
    localparam int unsigned SensIdxW = $clog2(WinLen + 1);
    localparam int unsigned LenW     = $clog2(TailMax + 2);

    localparam logic [7:0] ChDot = 8'h2e;

    localparam logic OpRequest  = 1'b0;
    localparam logic OpStubborn = 1'b1;

    localparam logic [1:0] StratNetwork = 2'd0;
    localparam logic [1:0] StratCache   = 2'd1;
    localparam logic [1:0] StratStale   = 2'd2;
    localparam logic [1:0] StratDefault = 2'd3;

    // right-aligned: index 0 is the final character
    localparam logic [WinLen:0][7:0] SensTxt [NumSens] = '{
        "/api/", "graphql", "token", "authorization", "cookie",
        "/login", "/logout", "/checkout", "/payment"
    };
    localparam logic [SensIdxW:0] SensLen [NumSens] = '{
        5'd5, 5'd7, 5'd5, 5'd13, 5'd6, 5'd6, 5'd7, 5'd9, 5'd8
    };

    localparam logic [TailMax-1:0][7:0] ExtTxt [NumExt] = '{
        ".js", ".css", ".woff2", ".png", ".jpg", ".webp"
    };
    localparam logic [LenW-1:0] ExtLen [NumExt] = '{
        3'd3, 3'd4, 3'd6, 3'd4, 3'd4, 3'd5
    };

    typedef struct packed {
        logic       op;
        logic [7:0] url_byte;
        logic       byte_present;
        logic       last_byte;
    } t_in_beat;

    typedef struct packed {
        logic [1:0] strategy;
        logic       sensitive_hit;
    } t_out_beat;

    typedef struct packed {
        logic en;
        logic clr;
    } t_cell_ctl;

    function automatic logic [7:0] fold_lower(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= 8'h41 && b <= 8'h5a) begin
            r = b + 8'h20;
        end
        return r;
    endfunction

endpackage

// ===== src/url_cache_strategy_classifier.sv =====
// channel | dir | handshake               | beat
// in      | in  | i_in_valid / o_in_ready | t_in_beat: op, url_byte, byte_present, last_byte
// out     | out | o_out_valid/i_out_ready | t_out_beat: strategy, sensitive_hit
// cfg     | in  | i_cfg_we                | i_cfg_wdata: ext_cache_mask
//
// One input beat per cycle while o_in_ready is high; a last beat's result is registered.
// Window of 12 byte cells shifts once per present byte; matching is done in the same cycle.
// A one-entry skid behind the output register keeps input flowing while out stalls.
// o_in_ready drops only while the skid entry is occupied.
// Synchronous active-low reset clears scan state and sets ext_cache_mask to all ones.
`include "url_cache_strategy_classifier_defines.svh"

module url_cache_strategy_classifier (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  ucsc_pkg::t_in_beat       i_in,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output ucsc_pkg::t_out_beat      o_out,
    input  logic                     i_cfg_we,
    input  logic [ucsc_pkg::NumExt-1:0] i_cfg_wdata
);

    logic [ucsc_pkg::NumExt-1:0] r_mask;
    logic                        r_seen;
    logic                        r_out_valid, r_skid_valid;
    ucsc_pkg::t_out_beat         r_out, r_skid, w_res;

    logic                        w_acc, w_res_valid, w_pop, w_hit_now, w_ext_hit;
    logic [7:0]                  w_byte;
    ucsc_pkg::t_cell_ctl         w_ctl;
    logic [7:0]                  w_q   [ucsc_pkg::WinLen];
    logic [ucsc_pkg::NumSens-1:0] w_hit [ucsc_pkg::WinLen];

    assign o_in_ready  = !r_skid_valid;
    assign w_acc       = i_in_valid && o_in_ready;
    assign w_res_valid = w_acc && i_in.last_byte;
    assign w_pop       = r_out_valid && i_out_ready;
    assign w_byte      = ucsc_pkg::fold_lower(i_in.url_byte);
    assign w_ctl.en    = w_acc && i_in.byte_present;
    assign w_ctl.clr   = w_res_valid;

    for (genvar g = 0; g < ucsc_pkg::WinLen; g++) begin : g_win
        ucsc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_pos   (ucsc_pkg::WinIdxW'(g)),
            .i_d     ((g == 0) ? w_byte : w_q[(g == 0) ? 0 : g - 1]),
            .o_q     (w_q[g]),
            .o_hit   (w_hit[g])
        );
    end

    ucsc_tail u_tail (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_byte    (w_byte),
        .i_mask    (r_mask),
        .o_ext_hit (w_ext_hit)
    );

    always_comb begin
        logic m;
        w_hit_now = 1'b0;
        for (int p = 0; p < ucsc_pkg::NumSens; p++) begin
            m = (w_byte == ucsc_pkg::SensTxt[p][0]);
            for (int c = 0; c < ucsc_pkg::WinLen; c++) begin
                m = m & w_hit[c][p];
            end
            w_hit_now = w_hit_now | m;
        end
        w_hit_now = w_hit_now & w_ctl.en;
    end

    always_comb begin
        w_res.sensitive_hit = r_seen | w_hit_now;
        if (i_in.op == ucsc_pkg::OpRequest && w_res.sensitive_hit) begin
            w_res.strategy = ucsc_pkg::StratNetwork;
        end else if (w_ext_hit) begin
            w_res.strategy = ucsc_pkg::StratCache;
        end else if (i_in.op == ucsc_pkg::OpRequest) begin
            w_res.strategy = ucsc_pkg::StratStale;
        end else begin
            w_res.strategy = ucsc_pkg::StratDefault;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '1;
        end else if (i_cfg_we) begin
            r_mask <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_ctl.clr) begin
            r_seen <= 1'b0;
        end else begin
            r_seen <= r_seen | w_hit_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_pop) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (w_res_valid) begin
            if (!r_out_valid || w_pop) begin
                r_out       <= w_res;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= w_res;
                r_skid_valid <= 1'b1;
            end
        end else if (w_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `UCSC_ASSERT_NOW(a_skid_behind_out, r_skid_valid, r_out_valid, "skid full, output empty")
    `UCSC_ASSERT_NXT(a_seen_cleared, w_res_valid, !r_seen, "sensitive mark kept past URL end")
    `UCSC_ASSERT_NOW(a_stubborn_no_net, w_res_valid && i_in.op == ucsc_pkg::OpStubborn,
                     w_res.strategy != ucsc_pkg::StratNetwork, "network-only in stubborn mode")
    `UCSC_ASSERT_NXT(a_res_lands, w_res_valid, r_out_valid, "result beat dropped")

endmodule

// ===== src/ucsc_cell.sv =====
module ucsc_cell (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ucsc_pkg::t_cell_ctl                i_ctl,
    input  logic [ucsc_pkg::WinIdxW-1:0]       i_pos,
    input  logic [7:0]                         i_d,
    output logic [7:0]                         o_q,
    output logic [ucsc_pkg::NumSens-1:0]       o_hit
);

    logic [7:0]                    r_q;
    logic [ucsc_pkg::SensIdxW-1:0] w_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_q <= '0;
        end else if (i_ctl.en) begin
            r_q <= i_d;
        end
    end

    // offset of this cell from the pattern end
    assign w_k = ucsc_pkg::SensIdxW'(i_pos) + 1'b1;

    always_comb begin
        for (int p = 0; p < ucsc_pkg::NumSens; p++) begin
            o_hit[p] = ({1'b0, w_k} >= ucsc_pkg::SensLen[p]) ||
                       (r_q == ucsc_pkg::SensTxt[p][w_k]);
        end
    end

    assign o_q = r_q;

endmodule

// ===== src/ucsc_tail.sv =====
`include "url_cache_strategy_classifier_defines.svh"

module ucsc_tail (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ucsc_pkg::t_cell_ctl           i_ctl,
    input  logic [7:0]                    i_byte,
    input  logic [ucsc_pkg::NumExt-1:0]   i_mask,
    output logic                          o_ext_hit
);

    logic [ucsc_pkg::TailMax-1:0][7:0] r_tail, n_tail;
    logic [ucsc_pkg::LenW-1:0]         r_len,  n_len;
    logic                              r_dot,  n_dot;
    logic                              w_match;

    always_comb begin
        n_tail = r_tail;
        n_len  = r_len;
        n_dot  = r_dot;
        if (i_ctl.en) begin
            if (i_byte == ucsc_pkg::ChDot) begin
                n_dot     = 1'b1;
                n_tail    = '0;
                n_tail[0] = i_byte;
                n_len     = ucsc_pkg::LenW'(1);
            end else if (r_dot) begin
                if (r_len < ucsc_pkg::LenW'(ucsc_pkg::TailMax)) begin
                    n_tail = {r_tail[ucsc_pkg::TailMax-2:0], i_byte};
                    n_len  = r_len + 1'b1;
                end else begin
                    n_len = ucsc_pkg::LenW'(ucsc_pkg::TailMax + 1);
                end
            end
        end
    end

    // newest byte in slot 0, so slot j lines up with character j from the end
    always_comb begin
        o_ext_hit = 1'b0;
        for (int i = 0; i < ucsc_pkg::NumExt; i++) begin
            w_match = n_dot && (n_len == ucsc_pkg::ExtLen[i]) && i_mask[i];
            for (int j = 0; j < ucsc_pkg::TailMax; j++) begin
                if (j < int'(ucsc_pkg::ExtLen[i]) && n_tail[j] != ucsc_pkg::ExtTxt[i][j]) begin
                    w_match = 1'b0;
                end
            end
            o_ext_hit = o_ext_hit | w_match;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_tail <= '0;
            r_len  <= '0;
            r_dot  <= 1'b0;
        end else begin
            r_tail <= n_tail;
            r_len  <= n_len;
            r_dot  <= n_dot;
        end
    end

    `UCSC_ASSERT_NOW(a_len_needs_dot, !r_dot, r_len == '0, "tail length without a dot")
    `UCSC_ASSERT_NXT(a_clr_empties, i_ctl.clr, !r_dot && r_len == '0, "tail not cleared")
    `UCSC_ASSERT_NXT(a_dot_starts, i_ctl.en && !i_ctl.clr && i_byte == ucsc_pkg::ChDot,
                     r_dot && r_len == ucsc_pkg::LenW'(1), "dot did not start tail")

endmodule

// ===== verif/url_cache_strategy_classifier_checker.sv =====
module url_cache_strategy_classifier_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  ucsc_pkg::t_in_beat          i_in,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  ucsc_pkg::t_out_beat         i_out,
    input  logic                        i_cfg_we,
    input  logic [ucsc_pkg::NumExt-1:0] i_cfg_wdata,
    output int                          o_fail_count,
    output int                          o_pending
);

    string sens_words [ucsc_pkg::NumSens] = '{
        "/api/", "graphql", "token", "authorization", "cookie",
        "/login", "/logout", "/checkout", "/payment"
    };
    string ext_words [ucsc_pkg::NumExt] = '{".js", ".css", ".woff2", ".png", ".jpg", ".webp"};

    logic [ucsc_pkg::NumExt-1:0] ext_mask;
    logic [7:0]                  recent [ucsc_pkg::WinLen+1];   // 0 is the newest byte
    logic                        sens_seen;
    logic                        dot_seen;
    logic [7:0]                  tail [ucsc_pkg::TailMax];
    int                          tail_len;            // TailMax+1 marks overflow
    ucsc_pkg::t_out_beat         strategy_q [$];
    int                          fails = 0;

    task automatic clear_url();
        for (int k = 0; k <= ucsc_pkg::WinLen; k++) recent[k] = 8'h00;
        for (int k = 0; k < ucsc_pkg::TailMax; k++) tail[k] = 8'h00;
        sens_seen = 1'b0;
        dot_seen  = 1'b0;
        tail_len  = 0;
    endtask

    task automatic absorb_byte(input logic [7:0] raw);
        logic [7:0] c;
        logic       hit;
        int         n;
        c = raw;
        if (c >= 8'h41 && c <= 8'h5a) begin
            c = c + 8'h20;
        end
        for (int k = ucsc_pkg::WinLen; k > 0; k--) recent[k] = recent[k-1];
        recent[0] = c;
        for (int p = 0; p < ucsc_pkg::NumSens; p++) begin
            n   = sens_words[p].len();
            hit = 1'b1;
            for (int k = 0; k < n; k++) begin
                if (recent[k] != sens_words[p][n-1-k]) hit = 1'b0;
            end
            if (hit) sens_seen = 1'b1;
        end
        if (c == ucsc_pkg::ChDot) begin
            dot_seen = 1'b1;
            for (int k = 0; k < ucsc_pkg::TailMax; k++) tail[k] = 8'h00;
            tail[0]  = c;
            tail_len = 1;
        end else if (dot_seen) begin
            if (tail_len < ucsc_pkg::TailMax) begin
                tail[tail_len] = c;
                tail_len++;
            end else begin
                tail_len = ucsc_pkg::TailMax + 1;
            end
        end
    endtask

    function automatic logic ext_cached();
        logic same;
        if (!dot_seen || tail_len == 0 || tail_len > ucsc_pkg::TailMax) return 1'b0;
        for (int e = 0; e < ucsc_pkg::NumExt; e++) begin
            if (ext_words[e].len() == tail_len) begin
                same = 1'b1;
                for (int k = 0; k < tail_len; k++) begin
                    if (tail[k] != ext_words[e][k]) same = 1'b0;
                end
                if (same) return ext_mask[e];
            end
        end
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin
        ucsc_pkg::t_out_beat want;
        if (!i_rst_n) begin
            clear_url();
            ext_mask = '1;
            strategy_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (strategy_q.size() == 0) begin
                    $error("result beat with none expected: strategy %0d sensitive_hit %0d",
                           i_out.strategy, i_out.sensitive_hit);
                    fails++;
                end else begin
                    want = strategy_q.pop_front();
                    if (i_out.strategy !== want.strategy) begin
                        $error("strategy: expected %0d, actual %0d",
                               want.strategy, i_out.strategy);
                        fails++;
                    end
                    if (i_out.sensitive_hit !== want.sensitive_hit) begin
                        $error("sensitive_hit: expected %0d, actual %0d",
                               want.sensitive_hit, i_out.sensitive_hit);
                        fails++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in.byte_present) absorb_byte(i_in.url_byte);
                if (i_in.last_byte) begin
                    want.sensitive_hit = sens_seen;
                    if (i_in.op == ucsc_pkg::OpRequest && sens_seen) begin
                        want.strategy = ucsc_pkg::StratNetwork;
                    end else if (ext_cached()) begin
                        want.strategy = ucsc_pkg::StratCache;
                    end else if (i_in.op == ucsc_pkg::OpRequest) begin
                        want.strategy = ucsc_pkg::StratStale;
                    end else begin
                        want.strategy = ucsc_pkg::StratDefault;
                    end
                    strategy_q.push_back(want);
                    clear_url();
                end
            end
            if (i_cfg_we) ext_mask = i_cfg_wdata;
        end
        o_pending    <= strategy_q.size();
        o_fail_count <= fails;
    end

endmodule

// ===== verif/tb_url_cache_strategy_classifier.sv =====
module tb_url_cache_strategy_classifier;

    localparam int CycleLimit = 200000;
    localparam int Latency    = 4;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_ready;
    ucsc_pkg::t_in_beat          in_beat;
    logic                        out_valid;
    logic                        out_ready;
    ucsc_pkg::t_out_beat         out_beat;
    logic                        cfg_we;
    logic [ucsc_pkg::NumExt-1:0] cfg_wdata;
    int                          fail_count;
    int                          pending;
    int                          cycles     = 0;
    int                          bytes_sent = 0;
    bit                          no_idle    = 1'b0;
    logic [7:0]                  url_q [$];

    string hot_words [ucsc_pkg::NumSens] = '{
        "/api/", "graphql", "token", "authorization", "cookie",
        "/login", "/logout", "/checkout", "/payment"
    };
    string ext_words [ucsc_pkg::NumExt] = '{".js", ".css", ".woff2", ".png", ".jpg", ".webp"};

    url_cache_strategy_classifier i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_beat),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    url_cache_strategy_classifier_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in         (in_beat),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out        (out_beat),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            out_ready = no_idle || ($urandom_range(99) >= 20);
        end
    end

    task automatic send_beat(input logic op, input logic [7:0] b, input logic present,
                             input logic last);
        @(negedge clk);
        while (!no_idle && $urandom_range(99) < 20) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_beat  = {op, b, present, last};
        do @(posedge clk); while (!in_ready);
        if (present) bytes_sent++;
    endtask

    task automatic send_url(input logic op, input bit absent_end, input bit noise);
        int n;
        n = url_q.size();
        for (int i = 0; i < n; i++) begin
            if (noise && $urandom_range(15) == 0) begin
                send_beat(1'($urandom_range(1)), 8'($urandom_range(255)), 1'b0, 1'b0);
            end
            send_beat((i == n - 1) ? op : 1'($urandom_range(1)), url_q[i], 1'b1,
                      (i == n - 1) && !absent_end);
        end
        if (absent_end || n == 0) send_beat(op, 8'($urandom_range(255)), 1'b0, 1'b1);
    endtask

    task automatic push_text(input string s, input bit mix_case);
        logic [7:0] c;
        for (int i = 0; i < s.len(); i++) begin
            c = s[i];
            if (mix_case && c >= 8'h61 && c <= 8'h7a && $urandom_range(1)) c = c - 8'h20;
            url_q.push_back(c);
        end
    endtask

    task automatic send_text(input string s, input logic op, input bit absent_end);
        url_q.delete();
        push_text(s, 1'b0);
        send_url(op, absent_end, 1'b0);
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (Latency) @(posedge clk);
    endtask

    task automatic write_mask(input logic [ucsc_pkg::NumExt-1:0] m);
        settle();
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = m;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    task automatic build_url();
        int n;
        url_q.delete();
        n = $urandom_range(5);
        for (int p = 0; p < n; p++) begin
            case ($urandom_range(9))
                0, 1, 2: begin
                    repeat ($urandom_range(1, 4)) url_q.push_back(8'(8'h61 + $urandom_range(25)));
                end
                3, 4: push_text(hot_words[$urandom_range(ucsc_pkg::NumSens - 1)], 1'b1);
                5: url_q.push_back(8'($urandom_range(255)));
                6, 7: begin
                    push_text(ext_words[$urandom_range(ucsc_pkg::NumExt - 1)], 1'b1);
                    if ($urandom_range(3) == 0) url_q.push_back(8'(8'h61 + $urandom_range(25)));
                end
                8: begin
                    url_q.push_back(ucsc_pkg::ChDot);
                    repeat ($urandom_range(1, 8)) url_q.push_back(8'(8'h61 + $urandom_range(25)));
                end
                default: url_q.push_back(8'h2f);
            endcase
        end
        if ($urandom_range(1)) push_text(ext_words[$urandom_range(ucsc_pkg::NumExt - 1)], 1'b1);
    endtask

    task automatic random_urls(input int n_bytes);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            build_url();
            send_url(1'($urandom_range(1)), $urandom_range(3) == 0, 1'b1);
        end
    endtask

    initial begin
        in_valid  = 1'b0;
        in_beat   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        rst_n     = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        send_text("", ucsc_pkg::OpRequest, 1'b0);
        send_text("", ucsc_pkg::OpStubborn, 1'b0);
        send_text("A.JS", ucsc_pkg::OpRequest, 1'b0);
        send_text("img/x.webp", ucsc_pkg::OpStubborn, 1'b1);
        send_text("/login.css", ucsc_pkg::OpRequest, 1'b0);
        send_text("tOkEn.png", ucsc_pkg::OpStubborn, 1'b0);
        send_text("AUTHORIZATION.js", ucsc_pkg::OpRequest, 1'b0);
        send_text("f.woff2x", ucsc_pkg::OpRequest, 1'b0);
        send_text("q.jpgzzz.woff2", ucsc_pkg::OpStubborn, 1'b0);
        send_text("nodot", ucsc_pkg::OpStubborn, 1'b0);
        // absent bytes must leave the tail alone
        url_q.delete();
        url_q.push_back(8'h00);
        url_q.push_back(8'hff);
        push_text("a.js", 1'b0);
        foreach (url_q[i]) send_beat(ucsc_pkg::OpStubborn, url_q[i], 1'b1, 1'b0);
        send_beat(ucsc_pkg::OpStubborn, 8'h78, 1'b0, 1'b0);
        send_beat(ucsc_pkg::OpRequest, ucsc_pkg::ChDot, 1'b0, 1'b1);

        random_urls(110);
        write_mask('0);
        random_urls(110);
        write_mask(6'h2a);
        no_idle = 1'b1;
        random_urls(110);
        no_idle = 1'b0;
        write_mask(6'h15);
        random_urls(110);
        write_mask(ucsc_pkg::NumExt'($urandom_range(63)));
        random_urls(80);
        write_mask('1);
        random_urls(80);
        settle();

        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/ucsc_pkg.sv
src/ucsc_cell.sv
src/ucsc_tail.sv
src/url_cache_strategy_classifier.sv
verif/url_cache_strategy_classifier_checker.sv
verif/tb_url_cache_strategy_classifier.sv
